>>> hw/rtl/bresenham_line_rasterizer_assert.svh
// Assertion macros for the line rasterizer.
// Used by bresenham_line_rasterizer.sv; needs nothing else.
`ifndef BRESENHAM_LINE_RASTERIZER_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_ASSERT_SVH

// same-cycle implication
`define BLR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BLR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/blr_pkg.sv
// Package for the line rasterizer: widths, word layout and sequencer states.
// No dependencies.
`default_nettype none

package blr_pkg;

    localparam int TILE_SIZE = 64;
    localparam int COORD_W   = $clog2(TILE_SIZE);
    localparam int COLOUR_W  = 2;
    // error term range is about +-2*TILE_SIZE
    localparam int ERR_W     = COORD_W + 3;

    localparam int CMD_BITS  = 4 * COORD_W + COLOUR_W;
    localparam int CMD_W     = ((CMD_BITS + 7) / 8) * 8;
    localparam int PIX_BITS  = 2 * COORD_W + COLOUR_W;
    localparam int PIX_W     = ((PIX_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } blr_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/bresenham_line_rasterizer.sv
// Bresenham line rasterizer: one line command in, one word per pixel out.
// Depends on blr_pkg and bresenham_line_rasterizer_assert.svh.
//
//  channel   dir  tdata (low bit up)                               tlast
//  s_axis    in   x_start, y_start, x_end, y_end, colour_code      -
//  m_axis    out  pixel_x, pixel_y, pixel_colour                   final_pixel
//
// A command is captured in idle and set up in ST_SETUP; then ST_RUN emits one pixel
// per cycle while the output is not stalled, max(|dx|,|dy|) pixels in all.
// The error term is updated by a single shared adder, one step per pixel.
// A stalled output register holds the sequencer; no pixel is dropped.
// s_axis_tready is high only in idle. Reset clears the state, output valid and pixel count.
`default_nettype none

`include "bresenham_line_rasterizer_assert.svh"

module bresenham_line_rasterizer
    import blr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // x_start, y_start, x_end, y_end, colour_code, zero pad
    input  wire logic [CMD_W-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // pixel_x, pixel_y, pixel_colour, zero pad
    output logic [PIX_W-1:0]      m_axis_tdata,
    output logic                  m_axis_tlast
);

    blr_state_t state_reg, state_next;

    logic [COORD_W-1:0]  xs_reg, ys_reg, xe_reg, ye_reg;
    logic [COLOUR_W-1:0] colour_reg;

    logic [COORD_W-1:0]       px_reg, px_next, py_reg, py_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic signed [ERR_W-1:0]  inc_pos_reg, inc_pos_next, inc_neg_reg, inc_neg_next;
    logic [COORD_W-1:0]       remain_reg, remain_next;
    logic                     shallow_reg, shallow_next;
    logic                     neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;

    logic                m_valid_reg, m_valid_next;
    logic [PIX_BITS-1:0] m_data_reg, m_data_next;
    logic                m_last_reg, m_last_next;

    // setup arithmetic
    logic signed [COORD_W:0] dx, dy;
    logic [COORD_W-1:0]      adx, ady, major, minor;
    logic                    shallow;

    logic                    accept, emit, err_nonneg;
    logic signed [ERR_W-1:0] err_inc;
    logic [COORD_W-1:0]      step_x, step_y;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign emit   = (state_reg == ST_RUN) && (!m_valid_reg || m_axis_tready);

    always_comb
    begin
        dx      = $signed({1'b0, xe_reg}) - $signed({1'b0, xs_reg});
        dy      = $signed({1'b0, ye_reg}) - $signed({1'b0, ys_reg});
        adx     = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ady     = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
        shallow = adx > ady;
        major   = shallow ? adx : ady;
        minor   = shallow ? ady : adx;
    end

    // shared error-term adder
    assign err_nonneg = !err_reg[ERR_W-1];
    assign err_inc    = err_nonneg ? inc_neg_reg : inc_pos_reg;
    assign step_x     = neg_x_reg ? {COORD_W{1'b1}} : COORD_W'(1);
    assign step_y     = neg_y_reg ? {COORD_W{1'b1}} : COORD_W'(1);

    always_comb
    begin
        state_next   = state_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        err_next     = err_reg;
        inc_pos_next = inc_pos_reg;
        inc_neg_next = inc_neg_reg;
        remain_next  = remain_reg;
        shallow_next = shallow_reg;
        neg_x_next   = neg_x_reg;
        neg_y_next   = neg_y_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        s_axis_tready = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                px_next      = xs_reg;
                py_next      = ys_reg;
                shallow_next = shallow;
                neg_x_next   = dx[COORD_W];
                neg_y_next   = dy[COORD_W];
                remain_next  = major;
                err_next     = ERR_W'({minor, 1'b0}) - ERR_W'(major);
                inc_pos_next = ERR_W'({minor, 1'b0});
                inc_neg_next = ERR_W'({minor, 1'b0}) - ERR_W'({major, 1'b0});
                state_next   = (major == '0) ? ST_IDLE : ST_RUN;
            end
            ST_RUN:
            begin
                if (emit)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {colour_reg, py_reg, px_reg};
                    m_last_next  = (remain_reg == COORD_W'(1));
                    err_next     = err_reg + err_inc;
                    if (shallow_reg || err_nonneg)
                    begin
                        px_next = px_reg + step_x;
                    end
                    if (!shallow_reg || err_nonneg)
                    begin
                        py_next = py_reg + step_y;
                    end
                    remain_next = remain_reg - COORD_W'(1);
                    if (remain_reg == COORD_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            remain_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            remain_reg  <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            xs_reg     <= s_axis_tdata[0*COORD_W +: COORD_W];
            ys_reg     <= s_axis_tdata[1*COORD_W +: COORD_W];
            xe_reg     <= s_axis_tdata[2*COORD_W +: COORD_W];
            ye_reg     <= s_axis_tdata[3*COORD_W +: COORD_W];
            colour_reg <= s_axis_tdata[4*COORD_W +: COLOUR_W];
        end
        px_reg      <= px_next;
        py_reg      <= py_next;
        err_reg     <= err_next;
        inc_pos_reg <= inc_pos_next;
        inc_neg_reg <= inc_neg_next;
        shallow_reg <= shallow_next;
        neg_x_reg   <= neg_x_next;
        neg_y_reg   <= neg_y_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = PIX_W'(m_data_reg);
    assign m_axis_tlast  = m_last_reg;

    `BLR_ASSERT_NXT(a_accept_setup, clk, rst_n, accept, state_reg == ST_SETUP,
        "command accepted but sequencer not in setup")
    `BLR_ASSERT_IMP(a_run_nonzero, clk, rst_n, state_reg == ST_RUN, remain_reg != '0,
        "sequencer running with no pixels left")
    `BLR_ASSERT_IMP(a_idle_done, clk, rst_n, s_axis_tready, remain_reg == '0,
        "ready for a command while pixels remain")
    `BLR_ASSERT_NXT(a_last_mark, clk, rst_n, emit && remain_reg == COORD_W'(1),
        m_axis_tvalid && m_axis_tlast, "final pixel not marked")

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for bresenham_line_rasterizer: line commands in, pixel words out.
// Needs blr_pkg and the rasterizer RTL; the expected pixels come from a behavioral stepper here.

module tb_top
    import blr_pkg::*;
;

    localparam logic [COLOUR_W-1:0] COL_BLUE  = 2'd0;
    localparam logic [COLOUR_W-1:0] COL_GREEN = 2'd1;
    localparam logic [COLOUR_W-1:0] COL_RED   = 2'd2;
    localparam logic [COLOUR_W-1:0] COL_SPARE = 2'd3;   // no colour meaning, passed through

    localparam int MAX_COORD   = TILE_SIZE - 1;
    localparam int DRAIN_LIMIT = 200000;
    localparam int TAIL_CYCLES = 80;

    // packed so that x_start sits in the low bits, as on s_axis_tdata
    typedef struct packed {
        logic [COLOUR_W-1:0] colour;
        logic [COORD_W-1:0]  y_end;
        logic [COORD_W-1:0]  x_end;
        logic [COORD_W-1:0]  y_start;
        logic [COORD_W-1:0]  x_start;
    } line_cmd_t;

    typedef struct {
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COLOUR_W-1:0] colour;
        logic                last;
    } pixel_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [CMD_W-1:0] s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [PIX_W-1:0] m_axis_tdata;
    logic             m_axis_tlast;

    pixel_t expected_pixels[$];

    int error_count    = 0;
    int lines_sent     = 0;
    int zero_lines     = 0;
    int steep_lines    = 0;
    int shallow_lines  = 0;
    int pixels_checked = 0;

    bit tx_gaps_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    int hold_request = 0;
    int hold_left    = 0;
    int rx_gap_left  = 0;

    bresenham_line_rasterizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(9) < 8)
            return $urandom_range(3, 1);
        return $urandom_range(25, 10);
    endfunction

    function automatic line_cmd_t line_of(input int xs, input int ys, input int xe,
                                          input int ye, input logic [COLOUR_W-1:0] col);
        line_cmd_t c;
        c.x_start = COORD_W'(xs);
        c.y_start = COORD_W'(ys);
        c.x_end   = COORD_W'(xe);
        c.y_end   = COORD_W'(ye);
        c.colour  = col;
        return c;
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < 0)
            return 0;
        if (v > MAX_COORD)
            return MAX_COORD;
        return v;
    endfunction

    // Step the line along its major axis; a tie in |dx|,|dy| counts as steep.
    task automatic predict_line_pixels(input line_cmd_t cmd);
        int     dx, dy, adx, ady, sx, sy, major, minor, err, px, py;
        bit     shallow;
        pixel_t p;
        dx      = int'(cmd.x_end) - int'(cmd.x_start);
        dy      = int'(cmd.y_end) - int'(cmd.y_start);
        adx     = (dx < 0) ? -dx : dx;
        ady     = (dy < 0) ? -dy : dy;
        sx      = (dx < 0) ? -1 : 1;
        sy      = (dy < 0) ? -1 : 1;
        shallow = (adx > ady);
        major   = shallow ? adx : ady;
        minor   = shallow ? ady : adx;
        err     = 2 * minor - major;
        px      = int'(cmd.x_start);
        py      = int'(cmd.y_start);
        lines_sent++;
        if (major == 0)
            zero_lines++;
        else if (shallow)
            shallow_lines++;
        else
            steep_lines++;
        for (int k = 0; k < major; k++)
        begin
            p.x      = COORD_W'(px);
            p.y      = COORD_W'(py);
            p.colour = cmd.colour;
            p.last   = (k == major - 1);
            expected_pixels = {expected_pixels, p};
            if (err >= 0)
            begin
                if (shallow)
                    py += sy;
                else
                    px += sx;
                err -= 2 * major;
            end
            err += 2 * minor;
            if (shallow)
                px += sx;
            else
                py += sy;
        end
    endtask

    // Called at a rising edge; valid stays up between back-to-back words.
    task automatic send_line(input line_cmd_t cmd);
        int gap;
        gap = 0;
        if (tx_gaps_on && $urandom_range(1) == 1)
            gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= CMD_W'(cmd);
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_line_pixels(cmd);
    endtask

    task automatic wait_idle();
        int waited;
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_pixels.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected pixels never arrived",
                                      expected_pixels.size()));
            expected_pixels.delete();
        end
        // a zero-length line may still be in the sequencer
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Output side: random stalls, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!rx_idle_on)
            m_axis_tready <= 1'b1;
        else if (rx_gap_left > 0)
        begin
            rx_gap_left--;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(9) < 3)
        begin
            rx_gap_left = pick_gap() - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_pixels
        pixel_t got;
        pixel_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.x      = m_axis_tdata[COORD_W-1:0];
            got.y      = m_axis_tdata[2*COORD_W-1:COORD_W];
            got.colour = m_axis_tdata[2*COORD_W+COLOUR_W-1:2*COORD_W];
            got.last   = m_axis_tlast;
            if (expected_pixels.size() == 0)
                report_mismatch($sformatf("unexpected pixel (%0d,%0d) colour %0d last %0b",
                                          got.x, got.y, got.colour, got.last));
            else
            begin
                want = expected_pixels.pop_front();
                if (got.x !== want.x)
                    report_mismatch($sformatf("pixel_x %0d, want %0d", got.x, want.x));
                if (got.y !== want.y)
                    report_mismatch($sformatf("pixel_y %0d, want %0d", got.y, want.y));
                if (got.colour !== want.colour)
                    report_mismatch($sformatf("pixel_colour %0d, want %0d",
                                              got.colour, want.colour));
                if (got.last !== want.last)
                    report_mismatch($sformatf("final_pixel %0b, want %0b at (%0d,%0d)",
                                              got.last, want.last, want.x, want.y));
                pixels_checked++;
            end
        end
    end

    // Axis extremes, all eight octants, diagonal ties, one-pixel and empty lines.
    task automatic test_directed();
        send_line(line_of(10, 20, 10, 20, COL_BLUE));
        send_line(line_of(0, 0, MAX_COORD, 0, COL_GREEN));
        send_line(line_of(MAX_COORD, MAX_COORD, 0, MAX_COORD, COL_RED));
        send_line(line_of(0, 0, 0, MAX_COORD, COL_SPARE));
        send_line(line_of(MAX_COORD, MAX_COORD, MAX_COORD, 0, COL_BLUE));
        send_line(line_of(0, 0, MAX_COORD, MAX_COORD, COL_GREEN));
        send_line(line_of(MAX_COORD, 0, 0, MAX_COORD, COL_RED));
        send_line(line_of(0, MAX_COORD, MAX_COORD, 0, COL_SPARE));
        send_line(line_of(MAX_COORD, MAX_COORD, 0, 0, COL_BLUE));
        send_line(line_of(32, 32, 50, 40, COL_GREEN));
        send_line(line_of(32, 32, 40, 50, COL_RED));
        send_line(line_of(32, 32, 24, 50, COL_SPARE));
        send_line(line_of(32, 32, 14, 40, COL_BLUE));
        send_line(line_of(32, 32, 14, 24, COL_GREEN));
        send_line(line_of(32, 32, 24, 14, COL_RED));
        send_line(line_of(32, 32, 40, 14, COL_SPARE));
        send_line(line_of(32, 32, 50, 24, COL_BLUE));
        send_line(line_of(5, 5, 6, 5, COL_GREEN));
        send_line(line_of(5, 5, 5, 4, COL_RED));
        send_line(line_of(0, 0, MAX_COORD, 1, COL_SPARE));
        send_line(line_of(0, MAX_COORD, 1, 0, COL_BLUE));
        wait_idle();
    endtask

    function automatic line_cmd_t random_line();
        int xs, ys, xe, ye, d, sel;
        xs  = $urandom_range(MAX_COORD);
        ys  = $urandom_range(MAX_COORD);
        sel = $urandom_range(99);
        if (sel < 60)
        begin
            xe = $urandom_range(MAX_COORD);
            ye = $urandom_range(MAX_COORD);
        end
        else if (sel < 85)
        begin
            xe = clamp_coord(xs + $urandom_range(8) - 4);
            ye = clamp_coord(ys + $urandom_range(8) - 4);
        end
        else if (sel < 95)
        begin
            // horizontal, vertical or diagonal (the clamp can bend a diagonal)
            d  = $urandom_range(MAX_COORD);
            xe = ($urandom_range(2) == 0) ? xs : d;
            ye = ($urandom_range(2) == 1) ? ys : ys + (d - xs) * ($urandom_range(1) ? 1 : -1);
            if (ye < 0 || ye > MAX_COORD)
                ye = ys + xs - d;
            ye = clamp_coord(ye);
        end
        else
        begin
            xe = xs;
            ye = ys;
        end
        return line_of(xs, ys, xe, ye, COLOUR_W'($urandom_range(3)));
    endfunction

    task automatic test_random_lines(input int count);
        tx_gaps_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (count)
            send_line(random_line());
        wait_idle();
    endtask

    // Output held off for a long stretch while long lines keep coming.
    task automatic test_output_backpressure(input int count);
        tx_gaps_on = 1'b0;
        rx_idle_on = 1'b1;
        @(negedge clk);
        hold_request = 300;
        @(posedge clk);
        repeat (count)
            send_line(line_of($urandom_range(7), $urandom_range(MAX_COORD),
                              $urandom_range(MAX_COORD, 40), $urandom_range(MAX_COORD),
                              COLOUR_W'($urandom_range(3))));
        wait_idle();
    endtask

    task automatic test_back_to_back(input int count);
        tx_gaps_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (count)
            send_line(random_line());
        wait_idle();
        tx_gaps_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_lines(250);
        test_output_backpressure(20);
        test_back_to_back(30);
        $display("Covered %0d line commands: %0d shallow, %0d steep, %0d zero-length.",
                 lines_sent, shallow_lines, steep_lines, zero_lines);
        $display("Checked %0d pixel words under random and long output stalls.",
                 pixels_checked);
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timeout with %0d pixels still expected", expected_pixels.size());
        $display("tb_top failed");
        $finish;
    end

endmodule
